// File: sv/segment_allocator_first_best_fit_top_macros.svh
// Assertion macros for the segment allocator checker.
// Included by the checker file only.
`ifndef SEGMENT_ALLOCATOR_FIRST_BEST_FIT_TOP_MACROS_SVH
`define SEGMENT_ALLOCATOR_FIRST_BEST_FIT_TOP_MACROS_SVH
// clocked implication, disabled in reset
`define SA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// clocked next-cycle implication, disabled in reset
`define SA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: sv/sa_pkg.sv
// Shared constants and types for the segment allocator.
// No dependencies.
`default_nettype none
package sa_pkg;
    localparam int MaxSegments = 16;
    localparam int AddrWidth   = 16;
    localparam int IdWidth     = 8;
    localparam int IdxWidth    = $clog2(MaxSegments);
    localparam int CntWidth    = 7;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StNoMem   = 2'd1;
    localparam logic [1:0] StNoOwner = 2'd2;
    localparam logic [1:0] StFull    = 2'd3;

    localparam logic RegMemSize   = 1'b0;
    localparam logic RegFitPolicy = 1'b1;

    localparam logic ReqAlloc = 1'b0;
    localparam logic ReqFree  = 1'b1;

    typedef struct packed {
        logic [AddrWidth-1:0] start;
        logic [AddrWidth-1:0] len;
        logic                 owned;
        logic [IdWidth-1:0]   owner;
    } t_seg;
endpackage
`default_nettype wire

// File: sv/segment_allocator_first_best_fit_top.sv
// Segment allocator with first/best fit and coalescing on free.
// Each item passes a scan of the table and a decision state, then for a split a shift of the
// entries above the hole, or for a free up to two merges, each followed by deleting one entry.
// Flow: one item at a time; the next input beat is taken the cycle after the result is
// registered, and a waiting result holds the block in its output state only for the next item.
// Reset (synchronous, active low) sets one hole [0, 1024); a mem_size write sets one hole [0, mem_size).
`default_nettype none
module segment_allocator_first_best_fit_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_owner_id,
    input  wire logic [15:0] i_req_size,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_grant_addr,
    output logic [6:0]       o_segment_count,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam logic [2:0] SIdle  = 3'd0;
    localparam logic [2:0] SScan  = 3'd1;
    localparam logic [2:0] SDec   = 3'd2;
    localparam logic [2:0] SShift = 3'd3;
    localparam logic [2:0] SMrgN  = 3'd4;
    localparam logic [2:0] SMrgP  = 3'd5;
    localparam logic [2:0] SDel   = 3'd6;
    localparam logic [2:0] SOut   = 3'd7;
    localparam int N = sa_pkg::MaxSegments;
    localparam int IW = sa_pkg::IdxWidth;
    localparam int CW = sa_pkg::CntWidth;

    sa_pkg::t_seg r_tab [N];
    logic [CW-1:0] r_total;
    logic          r_policy;
    logic [2:0]    r_state;
    logic          r_type;
    logic [7:0]    r_owner;
    logic [15:0]   r_size;
    logic [CW-1:0] r_i;
    logic [IW-1:0] r_pick;
    logic          r_found;
    logic          r_merged_next;
    logic [1:0]    r_status;
    logic [15:0]   r_addr;
    logic          r_ovalid;
    logic [1:0]    r_o_status;
    logic [15:0]   r_o_addr;
    logic [CW-1:0] r_o_count;

    sa_pkg::t_seg  w_cur;
    logic [IW-1:0] w_i;
    logic [16:0]   w_sum;
    logic          w_fit;
    logic          w_better;
    logic          w_acc;

    assign w_i   = r_i[IW-1:0];
    assign w_cur = r_tab[w_i];
    assign w_fit = !w_cur.owned && (w_cur.len >= r_size);
    assign w_better = !r_found || (r_policy && (w_cur.len < r_tab[r_pick].len));
    assign w_acc = i_valid && !o_stall;
    assign o_stall = (r_state != SIdle);
    assign o_valid = r_ovalid;
    assign o_status = r_o_status;
    assign o_grant_addr = r_o_addr;
    assign o_segment_count = r_o_count;

    always_comb begin
        case (r_state)
            SMrgN:   w_sum = {1'b0, r_tab[r_pick].len} + {1'b0, r_tab[r_pick + IW'(1)].len};
            SMrgP:   w_sum = {1'b0, r_tab[r_pick - IW'(1)].len} + {1'b0, r_tab[r_pick].len};
            default: w_sum = {1'b0, r_tab[r_pick].start} + {1'b0, r_size};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_we && i_cfg_index == sa_pkg::RegMemSize)) begin
            for (int k = 0; k < N; k++) begin
                r_tab[k].start <= '0;
                r_tab[k].len   <= '0;
                r_tab[k].owned <= 1'b0;
                r_tab[k].owner <= '0;
            end
            r_tab[0].len <= !i_rst_n ? 16'd1024 : i_cfg_data;
            r_total <= CW'(1);
        end else begin
            case (r_state)
                SDec: begin
                    if (r_type == sa_pkg::ReqAlloc && r_found
                            && r_tab[r_pick].len == r_size) begin
                        r_tab[r_pick].owned <= 1'b1;
                        r_tab[r_pick].owner <= r_owner;
                    end else if (r_type == sa_pkg::ReqFree && r_found) begin
                        r_tab[r_pick].owned <= 1'b0;
                        r_tab[r_pick].owner <= '0;
                    end
                end
                SShift: begin
                    if (r_i > CW'(r_pick) + CW'(1)) begin
                        r_tab[w_i] <= r_tab[w_i - IW'(1)];
                    end else begin
                        r_tab[r_pick + IW'(1)].start <= w_sum[15:0];
                        r_tab[r_pick + IW'(1)].len   <= r_tab[r_pick].len - r_size;
                        r_tab[r_pick + IW'(1)].owned <= 1'b0;
                        r_tab[r_pick + IW'(1)].owner <= '0;
                        r_tab[r_pick].len   <= r_size;
                        r_tab[r_pick].owned <= 1'b1;
                        r_tab[r_pick].owner <= r_owner;
                        r_total <= r_total + CW'(1);
                    end
                end
                SMrgN: begin
                    if (CW'(r_pick) + CW'(1) < r_total
                            && !r_tab[r_pick + IW'(1)].owned) begin
                        r_tab[r_pick].len <= w_sum[15:0];
                    end
                end
                SMrgP: begin
                    if (r_pick != '0 && !r_tab[r_pick - IW'(1)].owned) begin
                        r_tab[r_pick - IW'(1)].len <= w_sum[15:0];
                    end
                end
                SDel: begin
                    if (r_i + CW'(1) < r_total) begin
                        r_tab[w_i] <= r_tab[w_i + IW'(1)];
                    end else begin
                        r_tab[w_i] <= '0;
                        r_total <= r_total - CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= 1'b0;
            r_state    <= SIdle;
            r_ovalid   <= 1'b0;
            r_o_status <= '0;
            r_o_addr   <= '0;
            r_o_count  <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == sa_pkg::RegFitPolicy) r_policy <= i_cfg_data[0];
            if (r_state == SOut && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                SIdle: begin
                    if (w_acc) begin
                        r_type  <= i_req_type;
                        r_owner <= i_owner_id;
                        r_size  <= i_req_size;
                        r_i     <= '0;
                        r_pick  <= '0;
                        r_found <= 1'b0;
                        r_merged_next <= 1'b0;
                        r_state <= SScan;
                    end
                end
                SScan: begin
                    if (r_i >= r_total || (r_type == sa_pkg::ReqAlloc && r_size == '0)) begin
                        r_state <= SDec;
                    end else if (r_type == sa_pkg::ReqAlloc) begin
                        if (w_fit && w_better) begin
                            r_pick  <= w_i;
                            r_found <= 1'b1;
                        end
                        if ((w_fit && !r_policy) || r_i == CW'(N - 1)) r_state <= SDec;
                        else r_i <= r_i + CW'(1);
                    end else begin
                        if (w_cur.owned && w_cur.owner == r_owner) begin
                            r_pick  <= w_i;
                            r_found <= 1'b1;
                            r_state <= SDec;
                        end else if (r_i == CW'(N - 1)) r_state <= SDec;
                        else r_i <= r_i + CW'(1);
                    end
                end
                SDec: begin
                    r_addr <= '0;
                    if (r_type == sa_pkg::ReqAlloc) begin
                        if (!r_found || r_size == '0) begin
                            r_status <= sa_pkg::StNoMem;
                            r_state  <= SOut;
                        end else if (r_tab[r_pick].len == r_size) begin
                            r_status <= sa_pkg::StOk;
                            r_addr   <= r_tab[r_pick].start;
                            r_state  <= SOut;
                        end else if (r_total >= CW'(N)) begin
                            r_status <= sa_pkg::StFull;
                            r_state  <= SOut;
                        end else begin
                            r_status <= sa_pkg::StOk;
                            r_addr   <= r_tab[r_pick].start;
                            r_i      <= r_total;
                            r_state  <= SShift;
                        end
                    end else if (!r_found) begin
                        r_status <= sa_pkg::StNoOwner;
                        r_state  <= SOut;
                    end else begin
                        r_status <= sa_pkg::StOk;
                        r_state  <= SMrgN;
                    end
                end
                SShift: begin
                    if (r_i > CW'(r_pick) + CW'(1)) r_i <= r_i - CW'(1);
                    else r_state <= SOut;
                end
                SMrgN: begin
                    if (CW'(r_pick) + CW'(1) < r_total
                            && !r_tab[r_pick + IW'(1)].owned) begin
                        r_i <= CW'(r_pick) + CW'(1);
                        r_merged_next <= 1'b1;
                        r_state <= SDel;
                    end else begin
                        r_state <= SMrgP;
                    end
                end
                SMrgP: begin
                    if (r_pick != '0 && !r_tab[r_pick - IW'(1)].owned) begin
                        r_i <= CW'(r_pick);
                        r_merged_next <= 1'b0;
                        r_state <= SDel;
                    end else begin
                        r_state <= SOut;
                    end
                end
                SDel: begin
                    if (r_i + CW'(1) < r_total) r_i <= r_i + CW'(1);
                    else if (r_merged_next) begin
                        r_merged_next <= 1'b0;
                        r_state <= SMrgP;
                    end else r_state <= SOut;
                end
                SOut: begin
                    if (!r_ovalid || !i_stall) begin
                        r_o_status <= r_status;
                        r_o_addr   <= r_addr;
                        r_o_count  <= r_total;
                        r_state    <= SIdle;
                    end
                end
                default: r_state <= SIdle;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/sa_checker.sv
// Port-level checker for the segment allocator, bound to the top level.
// Depends on the assertion macro header and sa_pkg.
`default_nettype none
`include "segment_allocator_first_best_fit_top_macros.svh"
module sa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [15:0] o_grant_addr,
    input wire logic [6:0]  o_segment_count
);
    `SA_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "no busy after input beat")
    `SA_ASSERT_IMP(a_addr_zero, i_clk, i_rst_n, o_valid && o_status != sa_pkg::StOk, o_grant_addr == 16'd0, "nonzero address on failure")
    `SA_ASSERT_IMP(a_count_range, i_clk, i_rst_n, o_valid, o_segment_count != 7'd0 && o_segment_count <= 7'd16, "segment count out of range")
    `SA_ASSERT_NXT(a_hold_result, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_grant_addr), "stalled result changed")
endmodule
bind segment_allocator_first_best_fit_top sa_checker u_sa_checker (.*);
`default_nettype wire

// File: bench/segment_allocator_first_best_fit_top_tb.sv
// Testbench for the segment allocator: directed and random allocate/free beats,
// checked against an in-bench model of the segment table. Depends on sa_pkg.
`timescale 1ns / 1ps
module segment_allocator_first_best_fit_top_tb;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] addr;
        logic [6:0]  count;
    } t_grant;

    class alloc_scoreboard;
        sa_pkg::t_seg table_q[sa_pkg::MaxSegments];
        int          total;
        logic [15:0] mem_size;
        logic        best_fit;
        t_grant      pending[$];
        int          errors;
        int          checked;

        function void init_table();
            for (int i = 0; i < sa_pkg::MaxSegments; i++) table_q[i] = '0;
            table_q[0].len = mem_size;
            total = 1;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == sa_pkg::RegMemSize) begin
                mem_size = val;
                init_table();
            end else begin
                best_fit = val[0];
            end
        endfunction

        function void drop_entry(int k);
            for (int i = k; i + 1 < total; i++) table_q[i] = table_q[i+1];
            total--;
            table_q[total] = '0;
        endfunction

        function void note_request(logic kind, logic [7:0] id, logic [15:0] size);
            t_grant g;
            int     pick;
            int     c;
            pick = -1;
            g.status = sa_pkg::StOk;
            g.addr = '0;
            if (kind == sa_pkg::ReqAlloc) begin
                if (size != 0) begin
                    for (int i = 0; i < total; i++) begin
                        if (table_q[i].owned || table_q[i].len < size) continue;
                        if (pick < 0 || (best_fit && table_q[i].len < table_q[pick].len))
                            pick = i;
                        if (!best_fit) break;
                    end
                end
                if (pick < 0) begin
                    g.status = sa_pkg::StNoMem;
                end else if (table_q[pick].len > size && total >= sa_pkg::MaxSegments) begin
                    g.status = sa_pkg::StFull;
                end else begin
                    if (table_q[pick].len > size) begin
                        for (int i = total; i > pick + 1; i--) table_q[i] = table_q[i-1];
                        table_q[pick+1].start = table_q[pick].start + size;
                        table_q[pick+1].len = table_q[pick].len - size;
                        table_q[pick+1].owned = 1'b0;
                        table_q[pick+1].owner = '0;
                        table_q[pick].len = size;
                        total++;
                    end
                    table_q[pick].owned = 1'b1;
                    table_q[pick].owner = id;
                    g.addr = table_q[pick].start;
                end
            end else begin
                for (c = 0; c < total; c++)
                    if (table_q[c].owned && table_q[c].owner == id) break;
                if (c >= total) begin
                    g.status = sa_pkg::StNoOwner;
                end else begin
                    table_q[c].owned = 1'b0;
                    table_q[c].owner = '0;
                    if (c + 1 < total && !table_q[c+1].owned) begin
                        table_q[c].len = table_q[c].len + table_q[c+1].len;
                        drop_entry(c + 1);
                    end
                    if (c > 0 && !table_q[c-1].owned) begin
                        table_q[c-1].len = table_q[c-1].len + table_q[c].len;
                        drop_entry(c);
                    end
                end
            end
            g.count = 7'(total);
            pending.push_back(g);
        endfunction

        function void check_grant(logic [1:0] st, logic [15:0] ad, logic [6:0] cnt);
            t_grant g;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat st=%0d addr=%0d cnt=%0d",
                    st, ad, cnt);
                return;
            end
            g = pending.pop_front();
            if (g.status !== st || g.addr !== ad || g.count !== cnt) begin
                errors++;
                if (errors <= 10)
                    $display("beat %0d: exp st=%0d addr=%0d cnt=%0d got st=%0d addr=%0d cnt=%0d",
                        checked, g.status, g.addr, g.count, st, ad, cnt);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_owner_id = '0;
    logic [15:0] i_req_size = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_grant_addr;
    logic [6:0]  o_segment_count;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    alloc_scoreboard sb;
    int unsigned cycles = 0;
    int          stall_mode = 0;
    int          sent = 0;

    always #6 i_clk = ~i_clk;

    segment_allocator_first_best_fit_top DUT (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("segment_allocator_first_best_fit_top: mismatch");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall)
            sb.check_grant(o_status, o_grant_addr, o_segment_count);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ((cycles % 7) < 4);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    task automatic send_req(logic kind, logic [7:0] id, logic [15:0] size);
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_owner_id <= id;
        i_req_size <= size;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(kind, id, size);
        sent++;
    endtask

    task automatic pause_sender(int n);
        i_valid <= 1'b0;
        i_req_type <= 1'($urandom_range(0, 1));
        i_owner_id <= 8'($urandom_range(0, 255));
        i_req_size <= 16'($urandom_range(0, 65535));
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n, int id_range, int max_size);
        int burst;
        int k;
        k = 0;
        while (k < n) begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && k < n; j++) begin
                if ($urandom_range(0, 9) < 6)
                    send_req(sa_pkg::ReqAlloc, 8'($urandom_range(0, id_range)),
                        16'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, max_size)));
                else
                    send_req(sa_pkg::ReqFree, 8'($urandom_range(0, id_range)),
                        16'($urandom_range(0, 65535)));
                k++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
        end
    endtask

    initial begin
        sb = new();
        sb.mem_size = 16'd1024;
        sb.best_fit = 1'b0;
        sb.init_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, split, full table, merges, zero size
        send_req(sa_pkg::ReqAlloc, 8'd0, 16'd0);
        send_req(sa_pkg::ReqAlloc, 8'd255, 16'd65535);
        send_req(sa_pkg::ReqAlloc, 8'd1, 16'd100);
        send_req(sa_pkg::ReqAlloc, 8'd2, 16'd200);
        send_req(sa_pkg::ReqAlloc, 8'd3, 16'd50);
        send_req(sa_pkg::ReqFree, 8'd2, 16'd0);
        send_req(sa_pkg::ReqFree, 8'd9, 16'hffff);
        send_req(sa_pkg::ReqFree, 8'd1, 16'd0);
        send_req(sa_pkg::ReqFree, 8'd3, 16'd0);
        for (int i = 0; i < 16; i++) send_req(sa_pkg::ReqAlloc, 8'(i), 16'd10);
        send_req(sa_pkg::ReqAlloc, 8'd200, 16'd1);
        drain();
        write_reg(sa_pkg::RegFitPolicy, 16'hfffe);
        write_reg(sa_pkg::RegMemSize, 16'd0);
        send_req(sa_pkg::ReqAlloc, 8'd4, 16'd1);
        send_req(sa_pkg::ReqFree, 8'd4, 16'd1);
        drain();
        write_reg(sa_pkg::RegMemSize, 16'd65535);
        write_reg(sa_pkg::RegFitPolicy, 16'd1);
        send_req(sa_pkg::ReqAlloc, 8'd7, 16'd65535);
        send_req(sa_pkg::ReqFree, 8'd7, 16'd0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            stall_mode = ph % 4;
            case (ph % 4)
                0: write_reg(sa_pkg::RegMemSize, 16'd1024);
                1: write_reg(sa_pkg::RegMemSize, 16'($urandom_range(1, 65535)));
                2: write_reg(sa_pkg::RegMemSize, 16'd65535);
                default: write_reg(sa_pkg::RegMemSize, 16'd1);
            endcase
            write_reg(sa_pkg::RegFitPolicy, 16'(ph % 2));
            random_phase(190, (ph < 4) ? 15 : 255, (ph % 4 == 2) ? 20000 : 300);
            drain();
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("ran %0d request beats over both fit policies and several memory sizes",
            sent);
        $display("%0d result beats checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("segment_allocator_first_best_fit_top: match");
        else
            $display("segment_allocator_first_best_fit_top: mismatch");
        $finish;
    end
endmodule
